/* rtl/mqtt_hdr_pkg.sv */
// Shared types, codes and the status helper function of the MQTT fixed header parser.
package mqtt_hdr_pkg;

    localparam int LEN_W = 28;
    localparam int HALF_W = 16;
    localparam int MAX_LEN_BYTES = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] TYPE_CONNECT = 4'd1;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_PUBACK = 4'd4;
    localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;
    localparam logic [3:0] TYPE_PINGREQ = 4'd12;
    localparam logic [3:0] TYPE_DISCONNECT = 4'd14;

    localparam logic [3:0] FLAGS_CONNECT = 4'd0;
    localparam logic [3:0] FLAGS_SUBSCRIBE = 4'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MALFORMED   = 3'd1,
        ST_BAD_FLAGS   = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_TRUNCATED   = 3'd4
    } status_t;

    typedef struct packed {
        logic [3:0]        packet_type;
        logic [3:0]        header_flags;
        logic [LEN_W-1:0]  body_length;
        logic [HALF_W-1:0] topic_size;
        logic [HALF_W-1:0] msg_ident;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } emit_t;

    function automatic status_t final_status(input logic [3:0] ptype, input logic [3:0] flags);
        status_t st;
        st = ST_UNSUPPORTED;
        case (ptype)
            TYPE_CONNECT:   st = (flags == FLAGS_CONNECT) ? ST_OK : ST_BAD_FLAGS;
            TYPE_SUBSCRIBE: st = (flags == FLAGS_SUBSCRIBE) ? ST_OK : ST_BAD_FLAGS;
            TYPE_PUBLISH, TYPE_PUBACK, TYPE_PINGREQ, TYPE_DISCONNECT: st = ST_OK;
            default:        st = ST_UNSUPPORTED;
        endcase
        return st;
    endfunction

endpackage

/* rtl/mqtt_hdr_if.sv */
// Handshake interfaces for the byte requests and the parsed header results.
interface mqtt_hdr_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;

    modport source (output valid, output data_byte, output packet_start, input ready);
    modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface mqtt_hdr_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  packet_type;
    logic [3:0]  header_flags;
    logic [27:0] body_length;
    logic [15:0] topic_size;
    logic [15:0] msg_ident;
    logic [2:0]  status;

    modport source (output valid, output packet_type, output header_flags,
                    output body_length, output topic_size, output msg_ident,
                    output status, input ready);
    modport sink (input valid, input packet_type, input header_flags,
                  input body_length, input topic_size, input msg_ident,
                  input status, output ready);
endinterface

/* rtl/mqtt_hdr_parser.sv */
// Per-byte header state machine: fixed header split, length decode and body field capture.
module mqtt_hdr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 packet_start,
    output mqtt_hdr_pkg::emit_t  emit_out
);

    mqtt_hdr_pkg::phase_t                   phase_reg, phase_next;
    logic [3:0]                             type_reg, type_next;
    logic [3:0]                             flags_reg, flags_next;
    logic [mqtt_hdr_pkg::LEN_W-1:0]         length_reg, length_next;
    logic [2:0]                             len_cnt_reg, len_cnt_next;
    logic [mqtt_hdr_pkg::LEN_W-1:0]         body_cnt_reg, body_cnt_next;
    logic [mqtt_hdr_pkg::HALF_W-1:0]        topic_reg, topic_next;
    logic [mqtt_hdr_pkg::HALF_W-1:0]        ident_reg, ident_next;

    logic [mqtt_hdr_pkg::LEN_W-1:0]         len_group;
    logic [mqtt_hdr_pkg::HALF_W:0]          topic_p2;
    logic [mqtt_hdr_pkg::HALF_W:0]          topic_p3;
    logic                                   is_publish;
    logic                                   is_ident_only;
    mqtt_hdr_pkg::status_t                  status_now;

    assign topic_p2 = {1'b0, topic_reg} + 17'd2;
    assign topic_p3 = {1'b0, topic_reg} + 17'd3;
    assign is_publish = (type_reg == mqtt_hdr_pkg::TYPE_PUBLISH);
    assign is_ident_only = (type_reg == mqtt_hdr_pkg::TYPE_PUBACK)
                        || (type_reg == mqtt_hdr_pkg::TYPE_SUBSCRIBE);
    assign status_now = mqtt_hdr_pkg::final_status(type_reg, flags_reg);

    always_comb
    begin
        case (len_cnt_reg[1:0])
            2'd0:    len_group = {21'd0, data_byte[6:0]};
            2'd1:    len_group = {14'd0, data_byte[6:0], 7'd0};
            2'd2:    len_group = {7'd0, data_byte[6:0], 14'd0};
            default: len_group = {data_byte[6:0], 21'd0};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        type_next = type_reg;
        flags_next = flags_reg;
        length_next = length_reg;
        len_cnt_next = len_cnt_reg;
        body_cnt_next = body_cnt_reg;
        topic_next = topic_reg;
        ident_next = ident_reg;
        emit_out.emit = 1'b0;
        emit_out.res.packet_type = type_reg;
        emit_out.res.header_flags = flags_reg;
        emit_out.res.body_length = length_reg;
        emit_out.res.topic_size = '0;
        emit_out.res.msg_ident = '0;
        emit_out.res.status = mqtt_hdr_pkg::ST_TRUNCATED;

        if (accept)
        begin
            if (packet_start)
            begin
                // A new packet cuts short whatever packet is still open.
                emit_out.emit = (phase_reg != mqtt_hdr_pkg::PH_IDLE);
                emit_out.res.status = mqtt_hdr_pkg::ST_TRUNCATED;
                type_next = data_byte[7:4];
                flags_next = data_byte[3:0];
                length_next = '0;
                len_cnt_next = '0;
                body_cnt_next = '0;
                topic_next = '0;
                ident_next = '0;
                phase_next = mqtt_hdr_pkg::PH_LEN;
            end
            else
            begin
                case (phase_reg)
                    mqtt_hdr_pkg::PH_LEN:
                    begin
                        length_next = length_reg | len_group;
                        len_cnt_next = len_cnt_reg + 3'd1;
                        emit_out.res.body_length = length_next;
                        if (!data_byte[7])
                        begin
                            if (length_next == '0)
                            begin
                                emit_out.emit = 1'b1;
                                emit_out.res.status = status_now;
                                phase_next = mqtt_hdr_pkg::PH_IDLE;
                            end
                            else
                            begin
                                phase_next = mqtt_hdr_pkg::PH_BODY;
                            end
                        end
                        else if (len_cnt_next >= 3'(mqtt_hdr_pkg::MAX_LEN_BYTES))
                        begin
                            emit_out.emit = 1'b1;
                            emit_out.res.status = mqtt_hdr_pkg::ST_MALFORMED;
                            phase_next = mqtt_hdr_pkg::PH_IDLE;
                        end
                    end
                    mqtt_hdr_pkg::PH_BODY:
                    begin
                        if (is_publish)
                        begin
                            if (body_cnt_reg == 28'd0)
                                topic_next = {data_byte, topic_reg[7:0]};
                            else if (body_cnt_reg == 28'd1)
                                topic_next = {topic_reg[15:8], data_byte};
                            else if (body_cnt_reg == {11'd0, topic_p2})
                                ident_next = {data_byte, ident_reg[7:0]};
                            else if (body_cnt_reg == {11'd0, topic_p3})
                                ident_next = {ident_reg[15:8], data_byte};
                        end
                        else if (is_ident_only)
                        begin
                            if (body_cnt_reg == 28'd0)
                                ident_next = {data_byte, ident_reg[7:0]};
                            else if (body_cnt_reg == 28'd1)
                                ident_next = {ident_reg[15:8], data_byte};
                        end
                        body_cnt_next = body_cnt_reg + 28'd1;
                        if (body_cnt_next == length_reg)
                        begin
                            emit_out.emit = 1'b1;
                            emit_out.res.status = status_now;
                            if (status_now == mqtt_hdr_pkg::ST_OK)
                            begin
                                emit_out.res.topic_size = topic_next;
                                emit_out.res.msg_ident = ident_next;
                            end
                            phase_next = mqtt_hdr_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // Bytes outside a packet are dropped.
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mqtt_hdr_pkg::PH_IDLE;
            type_reg <= '0;
            flags_reg <= '0;
            length_reg <= '0;
            len_cnt_reg <= '0;
            body_cnt_reg <= '0;
            topic_reg <= '0;
            ident_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg <= type_next;
            flags_reg <= flags_next;
            length_reg <= length_next;
            len_cnt_reg <= len_cnt_next;
            body_cnt_reg <= body_cnt_next;
            topic_reg <= topic_next;
            ident_reg <= ident_next;
        end
    end

endmodule

/* rtl/mqtt_hdr_out_queue.sv */
// Two-entry result queue that decouples the parser from the result consumer.
module mqtt_hdr_out_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mqtt_hdr_pkg::emit_t    push,
    output logic                   can_push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mqtt_hdr_pkg::result_t  out_res
);

    mqtt_hdr_pkg::result_t slot_reg [mqtt_hdr_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign can_push = (count_reg != 2'(mqtt_hdr_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_res = slot_reg[rd_ptr_reg];
    assign do_push = push.emit && can_push;
    assign do_pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/mqtt_hdr_control_packet_header_parser_core.sv */
// Top level of the MQTT control packet fixed header parser.
// Each request carries one byte of the packet stream and one byte is taken in every
// clock cycle. The byte that completes a packet (or ends it as malformed, or a start
// byte that cuts an open packet short) produces one result, which is registered into
// a two-entry result queue and presented once earlier results are taken; requests
// stall only while both queue entries hold results that have not been taken.
module mqtt_control_packet_header_parser_core (
    input  logic           clk,
    input  logic           rst_n,
    mqtt_hdr_req_if.sink   in_chan,
    mqtt_hdr_res_if.source out_chan
);

    mqtt_hdr_pkg::emit_t   emit;
    mqtt_hdr_pkg::result_t head;
    logic                  can_push;
    logic                  accept;

    assign in_chan.ready = can_push;
    assign accept = in_chan.valid && can_push;

    mqtt_hdr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (in_chan.data_byte),
        .packet_start (in_chan.packet_start),
        .emit_out     (emit)
    );

    mqtt_hdr_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .can_push  (can_push),
        .out_valid (out_chan.valid),
        .out_ready (out_chan.ready),
        .out_res   (head)
    );

    assign out_chan.packet_type = head.packet_type;
    assign out_chan.header_flags = head.header_flags;
    assign out_chan.body_length = head.body_length;
    assign out_chan.topic_size = head.topic_size;
    assign out_chan.msg_ident = head.msg_ident;
    assign out_chan.status = head.status;

endmodule
